// ===== design/decimal_string_to_int64_core_macros.svh =====
// ----------------------------------------------------------------------------
// decimal_string_to_int64_core_macros.svh
// Assertion macros shared by the decimal string converter.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_INT64_CORE_MACROS_SVH
`define DECIMAL_STRING_TO_INT64_CORE_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define DS2I_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define DS2I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ds2i_pkg.sv =====
// ----------------------------------------------------------------------------
// ds2i_pkg
// Types and constants of the decimal string to 64-bit integer converter.
// ----------------------------------------------------------------------------
package ds2i_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int CNT_W   = 5;
    localparam int DIGIT_W = 4;

    localparam int MAX_DIGITS_DEFAULT = 19;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef enum logic [1:0] {
        PHASE_START  = 2'd0,
        PHASE_NUMBER = 2'd1,
        PHASE_SKIP   = 2'd2
    } phase_t;

endpackage

// ===== design/ds2i_char_if.sv =====
// ----------------------------------------------------------------------------
// ds2i_char_if
// Valid/ready channel carrying one character of a buffer per beat.
// ----------------------------------------------------------------------------
interface ds2i_char_if;

    logic                           valid;
    logic                           ready;
    logic [ds2i_pkg::CHAR_W-1:0]    char_byte;
    logic                           buffer_last;

    modport source (output valid, output char_byte, output buffer_last, input ready);
    modport sink   (input valid, input char_byte, input buffer_last, output ready);

endinterface

// ===== design/ds2i_result_if.sv =====
// ----------------------------------------------------------------------------
// ds2i_result_if
// Valid/ready channel carrying one parse result per beat.
// ----------------------------------------------------------------------------
interface ds2i_result_if;

    logic                           valid;
    logic                           ready;
    logic [ds2i_pkg::VALUE_W-1:0]   parsed_value;
    logic [ds2i_pkg::CNT_W-1:0]     chars_consumed;
    logic                           parse_status;

    modport source (output valid, output parsed_value, output chars_consumed,
                    output parse_status, input ready);
    modport sink   (input valid, input parsed_value, input chars_consumed,
                    input parse_status, output ready);

endinterface

// ===== design/ds2i_in_reg.sv =====
// ----------------------------------------------------------------------------
// ds2i_in_reg
// Input register stage: holds one character beat in front of the parser.
// ----------------------------------------------------------------------------
module ds2i_in_reg (
    input  logic        clk,
    input  logic        rst_n,
    ds2i_char_if.sink   up,
    ds2i_char_if.source dn
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ds2i_pkg::CHAR_W-1:0] char_reg;
    logic                        last_reg;
    logic                        up_fire;

    assign up.ready = !valid_reg || dn.ready;
    assign up_fire  = up.valid && up.ready;

    always_comb
    begin
        if (up_fire)
        begin
            valid_next = 1'b1;
        end
        else if (dn.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_fire)
        begin
            char_reg <= up.char_byte;
            last_reg <= up.buffer_last;
        end
    end

    assign dn.valid       = valid_reg;
    assign dn.char_byte   = char_reg;
    assign dn.buffer_last = last_reg;

endmodule

// ===== design/ds2i_parser.sv =====
// ----------------------------------------------------------------------------
// ds2i_parser
// Parse state, digit accumulation and the result register.
// ----------------------------------------------------------------------------
module ds2i_parser #(
    parameter int MAX_DIGITS = ds2i_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          signed_mode,
    ds2i_char_if.sink     chr,
    ds2i_result_if.source res
);

    localparam int VW = ds2i_pkg::VALUE_W;
    localparam int CW = ds2i_pkg::CNT_W;
    localparam int DW = ds2i_pkg::DIGIT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

    ds2i_pkg::phase_t phase_reg;
    ds2i_pkg::phase_t phase_next;
    logic [VW-1:0]    acc_reg;
    logic [VW-1:0]    acc_next;
    // The negated magnitude is kept alongside, so no negation follows the multiply.
    logic [VW-1:0]    nacc_reg;
    logic [VW-1:0]    nacc_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             neg_reg;
    logic             neg_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [VW-1:0]    out_value_reg;
    logic [CW-1:0]    out_count_reg;
    logic             out_status_reg;

    logic             adv;
    logic             is_digit;
    logic             is_minus_start;
    logic             in_number;
    logic             emit;
    logic [DW-1:0]    digit;
    logic [VW-1:0]    acc_upd;
    logic [VW-1:0]    nacc_upd;
    logic [CW-1:0]    cnt_upd;
    logic             neg_upd;
    logic             err;
    logic [VW-1:0]    emit_value;
    logic [CW-1:0]    emit_count;

    assign chr.ready = !out_valid_reg || res.ready;
    assign adv       = chr.valid && chr.ready;

    assign is_digit       = (chr.char_byte >= ds2i_pkg::CHAR_ZERO)
                         && (chr.char_byte <= ds2i_pkg::CHAR_NINE);
    assign digit          = DW'(chr.char_byte - ds2i_pkg::CHAR_ZERO);
    assign is_minus_start = (phase_reg == ds2i_pkg::PHASE_START) && signed_mode
                         && (chr.char_byte == ds2i_pkg::CHAR_MINUS);
    assign in_number      = (phase_reg == ds2i_pkg::PHASE_START)
                         || (phase_reg == ds2i_pkg::PHASE_NUMBER);

    // Next parse phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (adv)
        begin
            if (chr.buffer_last)
            begin
                phase_next = ds2i_pkg::PHASE_START;
            end
            else
            begin
                unique case (phase_reg)
                    ds2i_pkg::PHASE_START,
                    ds2i_pkg::PHASE_NUMBER:
                    begin
                        if (is_minus_start || is_digit)
                        begin
                            phase_next = ds2i_pkg::PHASE_NUMBER;
                        end
                        else
                        begin
                            phase_next = ds2i_pkg::PHASE_SKIP;
                        end
                    end
                    default:
                    begin
                        phase_next = ds2i_pkg::PHASE_SKIP;
                    end
                endcase
            end
        end
    end

    // Datapath and result.
    always_comb
    begin
        acc_upd  = acc_reg;
        nacc_upd = nacc_reg;
        cnt_upd  = cnt_reg;
        neg_upd  = neg_reg;
        emit     = 1'b0;
        if (is_minus_start)
        begin
            neg_upd = 1'b1;
            emit    = chr.buffer_last;
        end
        else if (in_number)
        begin
            if (is_digit)
            begin
                if (cnt_reg < MAX_CNT)
                begin
                    acc_upd  = (acc_reg << 3) + (acc_reg << 1) + VW'(digit);
                    nacc_upd = (nacc_reg << 3) + (nacc_reg << 1) - VW'(digit);
                end
                if (cnt_reg <= MAX_CNT)
                begin
                    cnt_upd = cnt_reg + 1'b1;
                end
                emit = chr.buffer_last;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        err        = (cnt_upd == '0) || (cnt_upd > MAX_CNT);
        emit_value = err ? '0 : (neg_upd ? nacc_upd : acc_upd);
        emit_count = err ? '0 : (cnt_upd + CW'(neg_upd));

        if (adv && chr.buffer_last)
        begin
            acc_next  = '0;
            nacc_next = '0;
            cnt_next  = '0;
            neg_next  = 1'b0;
        end
        else if (adv)
        begin
            acc_next  = acc_upd;
            nacc_next = nacc_upd;
            cnt_next  = cnt_upd;
            neg_next  = neg_upd;
        end
        else
        begin
            acc_next  = acc_reg;
            nacc_next = nacc_reg;
            cnt_next  = cnt_reg;
            neg_next  = neg_reg;
        end

        if (adv && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ds2i_pkg::PHASE_START;
            acc_reg       <= '0;
            nacc_reg      <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            nacc_reg      <= nacc_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_value_reg  <= emit_value;
            out_count_reg  <= emit_count;
            out_status_reg <= err;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.parsed_value   = out_value_reg;
    assign res.chars_consumed = out_count_reg;
    assign res.parse_status   = out_status_reg;

endmodule

// ===== design/decimal_string_to_int64_core.sv =====
// ----------------------------------------------------------------------------
// decimal_string_to_int64_core
// Converts a buffer of decimal characters into a 64-bit integer result.
//
//   channel      dir  beat payload
//   char_in      in   char_byte, buffer_last
//   result_out   out  parsed_value, chars_consumed, parse_status
//   cfg_write_*  in   signed_mode (write only)
//
// One character is taken every cycle while char_in.ready is high. A character
// is held in the input register; its result, if any, is then registered in the
// result register, and the times-ten-plus-digit shift-add between the two sets
// the cycle time. When the result register is full and not taken, the input
// register fills and char_in.ready drops. Reset clears the parse state to the
// start of a buffer and signed_mode to unsigned.
// ----------------------------------------------------------------------------
`include "decimal_string_to_int64_core_macros.svh"

module decimal_string_to_int64_core #(
    parameter int MAX_DIGITS = ds2i_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic          cfg_write_data,
    ds2i_char_if.sink     char_in,
    ds2i_result_if.source result_out
);

    localparam int CW = ds2i_pkg::CNT_W;

    logic signed_mode_reg;

    ds2i_char_if stage ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            signed_mode_reg <= cfg_write_data;
        end
    end

    ds2i_in_reg u_in_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (char_in),
        .dn    (stage)
    );

    ds2i_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .signed_mode (signed_mode_reg),
        .chr         (stage),
        .res         (result_out)
    );

    `DS2I_ASSERT_IMPL(a_stall_cause, !char_in.ready,
        stage.valid && result_out.valid && !result_out.ready,
        "input stalled without a full pipeline")

    `DS2I_ASSERT_NEXT(a_accept_fills_stage, char_in.valid && char_in.ready,
        stage.valid, "accepted beat missing from the input register")

    `DS2I_ASSERT_IMPL(a_error_zero, result_out.valid && result_out.parse_status,
        (result_out.parsed_value == '0) && (result_out.chars_consumed == '0),
        "error result with nonzero value or count")

    `DS2I_ASSERT_IMPL(a_ok_count, result_out.valid && !result_out.parse_status,
        (result_out.chars_consumed != '0)
            && (result_out.chars_consumed <= CW'(MAX_DIGITS + 1)),
        "good result with an impossible character count")

endmodule
